FILE: rtl/core/dtt_pkg.sv
package dtt_pkg;

	// field and dimension widths
	localparam int IN_W      = 16;
	localparam int CFG_W     = 13;
	localparam int MAX_DIM   = 4096;
	localparam int DIM_W     = $clog2(MAX_DIM);
	localparam int CFG_IDX_W = 1;

	// CORDIC set-up
	localparam int CORDIC_STEPS = 16;
	localparam int TAB_LEN      = 24;
	localparam int CORDIC_ITERS = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
	localparam int STEP_W       = 5;
	localparam int CW           = 36;   // rotated vector components
	localparam int AW           = 34;   // angle accumulator, units of pi/2^31
	localparam int ANG_SHIFT    = 16;   // components scaled by 2^16

	// square root: 32 result bits, one per cell
	localparam int SQ_W   = 2 * IN_W;
	localparam int ROOT_W = 32;
	localparam int REM_W  = ROOT_W + 1;

	// angle and scaling widths
	localparam int ANG16_W = 16;
	localparam int PROD_W  = ANG16_W + DIM_W;

	localparam logic signed [AW-1:0] ANG_PI = AW'(64'd1 << 31);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] MAP_HEIGHT_RST = CFG_W'(1024);
	localparam logic [CFG_W-1:0] MAP_WIDTH_RST  = CFG_W'(2048);

	typedef struct packed {
		logic signed [IN_W-1:0] dir_x;
		logic signed [IN_W-1:0] dir_y;
		logic signed [IN_W-1:0] dir_z;
	} dir_req_t;

	typedef struct packed {
		logic [DIM_W-1:0] texel_row;
		logic [DIM_W-1:0] texel_col;
	} texel_t;

	// effective map size minus one
	typedef struct packed {
		logic [DIM_W-1:0] hm1;
		logic [DIM_W-1:0] wm1;
	} dims_t;

	typedef struct packed {
		logic signed [CW-1:0] num;
		logic signed [CW-1:0] den;
		logic signed [AW-1:0] ang;
	} cordic_t;

	// front chain: square root of x^2+y^2 alongside the azimuth CORDIC
	typedef struct packed {
		logic [SQ_W-1:0]        rad;
		logic [ROOT_W-1:0]      root;
		logic [REM_W-1:0]       rem;
		logic signed [IN_W-1:0] z;
		cordic_t                phi;
		logic                   phi_zero;
		logic                   all_zero;
	} front_t;

	// back chain: polar CORDIC, azimuth already rounded
	typedef struct packed {
		cordic_t             theta;
		logic [ANG16_W-1:0]  phi16;
		logic                all_zero;
	} theta_t;

	// round(atan(2^-i)/pi * 2^31)
	function automatic logic signed [AW-1:0] atan_entry(input logic [STEP_W-1:0] i);
		logic signed [AW-1:0] v;
		case (i)
			5'd0:  v = AW'(536870912);
			5'd1:  v = AW'(316933406);
			5'd2:  v = AW'(167458907);
			5'd3:  v = AW'(85004756);
			5'd4:  v = AW'(42667331);
			5'd5:  v = AW'(21354465);
			5'd6:  v = AW'(10679838);
			5'd7:  v = AW'(5340245);
			5'd8:  v = AW'(2670163);
			5'd9:  v = AW'(1335087);
			5'd10: v = AW'(667544);
			5'd11: v = AW'(333772);
			5'd12: v = AW'(166886);
			5'd13: v = AW'(83443);
			5'd14: v = AW'(41722);
			5'd15: v = AW'(20861);
			5'd16: v = AW'(10430);
			5'd17: v = AW'(5215);
			5'd18: v = AW'(2608);
			5'd19: v = AW'(1304);
			5'd20: v = AW'(652);
			5'd21: v = AW'(326);
			5'd22: v = AW'(163);
			5'd23: v = AW'(81);
			default: v = '0;
		endcase
		return v;
	endfunction

	// one vectoring rotation, driving num towards zero
	function automatic cordic_t cordic_step(input cordic_t c, input logic [STEP_W-1:0] i);
		logic signed [CW-1:0] num;
		logic signed [CW-1:0] den;
		logic signed [AW-1:0] ang;
		cordic_t r;
		num = c.num;
		den = c.den;
		ang = c.ang;
		if (num >= 0) begin
			r.den = den + (num >>> i);
			r.num = num - (den >>> i);
			r.ang = ang + atan_entry(i);
		end else begin
			r.den = den - (num >>> i);
			r.num = num + (den >>> i);
			r.ang = ang - atan_entry(i);
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/dtt_front_cell.sv
module dtt_front_cell import dtt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [STEP_W-1:0] step,
	input  logic              up_valid,
	output logic              up_ready,
	input  front_t            up_data,
	output logic              dn_valid,
	input  logic              dn_ready,
	output front_t            dn_data
);

	logic   valid_s1;
	front_t data_s1;
	front_t next;

	logic [REM_W+1:0] cur;
	logic [REM_W+1:0] trial;

	// one root bit, plus one azimuth rotation in the first cells
	always_comb begin
		next  = up_data;
		cur   = {up_data.rem, up_data.rad[SQ_W-1 -: 2]};
		trial = {1'b0, up_data.root, 2'b01};
		next.rad = {up_data.rad[SQ_W-3:0], 2'b00};
		if (cur >= trial) begin
			next.rem  = REM_W'(cur - trial);
			next.root = {up_data.root[ROOT_W-2:0], 1'b1};
		end else begin
			next.rem  = cur[REM_W-1:0];
			next.root = {up_data.root[ROOT_W-2:0], 1'b0};
		end
		if (step < STEP_W'(CORDIC_ITERS)) begin
			next.phi = cordic_step(up_data.phi, step);
		end
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_s1 <= next;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

FILE: rtl/core/dtt_theta_cell.sv
module dtt_theta_cell import dtt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [STEP_W-1:0] step,
	input  logic              up_valid,
	output logic              up_ready,
	input  theta_t            up_data,
	output logic              dn_valid,
	input  logic              dn_ready,
	output theta_t            dn_data
);

	logic   valid_s1;
	theta_t data_s1;
	theta_t next;

	// one polar rotation
	always_comb begin
		next       = up_data;
		next.theta = cordic_step(up_data.theta, step);
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_s1 <= next;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

FILE: rtl/core/dtt_scale.sv
module dtt_scale import dtt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  dims_t  dims,
	input  logic   up_valid,
	output logic   up_ready,
	input  theta_t up_data,
	output logic   dn_valid,
	input  logic   dn_ready,
	output texel_t dn_data
);

	logic              valid_s1;
	logic              valid_s2;
	logic              ready_s2;
	logic [PROD_W-1:0] prod_row_s1;
	logic [PROD_W-1:0] prod_col_s1;
	texel_t            texel_s2;

	logic [AW-1:0]      t_sat;
	logic [32:0]        t_sum;
	logic [ANG16_W-1:0] theta16;
	logic [PROD_W:0]    row_sum;
	logic [PROD_W:0]    col_sum;
	logic [DIM_W+1:0]   row_full;
	logic [DIM_W:0]     col_full;
	texel_t             texel_d;

	// saturate theta to [0, pi] and round to 16-bit fraction of pi
	always_comb begin
		if (up_data.theta.ang < 0) begin
			t_sat = '0;
		end else if (up_data.theta.ang > ANG_PI) begin
			t_sat = ANG_PI;
		end else begin
			t_sat = up_data.theta.ang;
		end
		t_sum = {1'b0, t_sat[31:0]} + 33'd32768;
		if (up_data.all_zero) begin
			theta16 = '0;
		end else begin
			theta16 = t_sum[31:16];
		end
	end

	// round half up, clamp, mirror the column
	always_comb begin
		row_sum  = {1'b0, prod_row_s1} + (PROD_W+1)'(16384);
		col_sum  = {1'b0, prod_col_s1} + (PROD_W+1)'(32768);
		row_full = row_sum[PROD_W:15];
		col_full = col_sum[PROD_W:16];
		if (row_full > (DIM_W+2)'(dims.hm1)) begin
			texel_d.texel_row = dims.hm1;
		end else begin
			texel_d.texel_row = row_full[DIM_W-1:0];
		end
		if (col_full > (DIM_W+1)'(dims.wm1)) begin
			texel_d.texel_col = '0;
		end else begin
			texel_d.texel_col = dims.wm1 - col_full[DIM_W-1:0];
		end
	end

	assign ready_s2 = !valid_s2 || dn_ready;
	assign up_ready = !valid_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (up_ready) begin
				valid_s1 <= up_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// multipliers
	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			prod_row_s1 <= theta16 * dims.hm1;
			prod_col_s1 <= up_data.phi16 * dims.wm1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			texel_s2 <= texel_d;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_data  = texel_s2;

endmodule

FILE: rtl/core/direction_to_equirect_texel_core.sv
// channel   | handshake                 | payload
// ----------+---------------------------+------------------------------
// dir       | dir_valid / dir_ready     | dir_req_t: dir_x, dir_y, dir_z
// texel     | texel_valid / texel_ready | texel_t: texel_row, texel_col
// cfg       | cfg_we                    | cfg_index, cfg_data
//
// Stages: input stage, 32 square-root cells (one root bit each, the azimuth
// CORDIC riding along), 16 polar CORDIC cells, two scaling stages. One request
// per cycle unless stalled. Reset clears every valid bit and loads 1024 x 2048.
// Each cell stalls only when it is full and its neighbour is; bubbles close up.
module direction_to_equirect_texel_core import dtt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 dir_valid,
	output logic                 dir_ready,
	input  dir_req_t             dir,
	output logic                 texel_valid,
	input  logic                 texel_ready,
	output texel_t               texel
);

	logic [CFG_W-1:0] map_height_q;
	logic [CFG_W-1:0] map_width_q;
	dims_t            dims;

	logic              valid_s1;
	dir_req_t          dir_s1;
	logic [SQ_W-1:0]   xx_s1;
	logic [SQ_W-1:0]   yy_s1;

	logic   front_valid [0:ROOT_W];
	logic   front_ready [0:ROOT_W];
	front_t front_d     [0:ROOT_W];

	logic   theta_valid [0:CORDIC_ITERS];
	logic   theta_ready [0:CORDIC_ITERS];
	theta_t theta_d     [0:CORDIC_ITERS];

	logic signed [CW-1:0] xe;
	logic signed [CW-1:0] ye;
	logic signed [CW-1:0] ze;
	logic signed [CW-1:0] re;
	logic [31:0]          phi_sum;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_height_q <= MAP_HEIGHT_RST;
			map_width_q  <= MAP_WIDTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAP_HEIGHT: map_height_q <= cfg_data;
				REG_MAP_WIDTH:  map_width_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective size minus one: zero reads as one, oversize as the maximum
	function automatic logic [DIM_W-1:0] dim_m1(input logic [CFG_W-1:0] r);
		logic [DIM_W-1:0] v;
		if (r == '0) begin
			v = '0;
		end else if (r > CFG_W'(MAX_DIM)) begin
			v = DIM_W'(MAX_DIM - 1);
		end else begin
			v = DIM_W'(r - CFG_W'(1));
		end
		return v;
	endfunction

	assign dims.hm1 = dim_m1(map_height_q);
	assign dims.wm1 = dim_m1(map_width_q);

	// input stage with the squares
	assign dir_ready = !valid_s1 || front_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (dir_ready) begin
			valid_s1 <= dir_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (dir_valid && dir_ready) begin
			dir_s1 <= dir;
			xx_s1  <= SQ_W'(dir.dir_x * dir.dir_x);
			yy_s1  <= SQ_W'(dir.dir_y * dir.dir_y);
		end
	end

	// azimuth set-up: turn by pi for negative x
	always_comb begin
		xe = CW'(dir_s1.dir_x) <<< ANG_SHIFT;
		ye = CW'(dir_s1.dir_y) <<< ANG_SHIFT;
		front_d[0].rad  = xx_s1 + yy_s1;
		front_d[0].root = '0;
		front_d[0].rem  = '0;
		front_d[0].z    = dir_s1.dir_z;
		if (dir_s1.dir_x < 0) begin
			front_d[0].phi.den = -xe;
			front_d[0].phi.num = -ye;
			front_d[0].phi.ang = ANG_PI;
		end else begin
			front_d[0].phi.den = xe;
			front_d[0].phi.num = ye;
			front_d[0].phi.ang = '0;
		end
		front_d[0].phi_zero = (dir_s1.dir_x == '0) && (dir_s1.dir_y == '0);
		front_d[0].all_zero = front_d[0].phi_zero && (dir_s1.dir_z == '0);
	end

	assign front_valid[0] = valid_s1;

	genvar k;
	generate
		for (k = 0; k < ROOT_W; k++) begin : g_front
			dtt_front_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.step     (STEP_W'(k)),
				.up_valid (front_valid[k]),
				.up_ready (front_ready[k]),
				.up_data  (front_d[k]),
				.dn_valid (front_valid[k+1]),
				.dn_ready (front_ready[k+1]),
				.dn_data  (front_d[k+1])
			);
		end
	endgenerate

	// polar set-up from the root and z; azimuth rounded to 16 bits
	always_comb begin
		ze = CW'(front_d[ROOT_W].z) <<< ANG_SHIFT;
		re = signed'(CW'(front_d[ROOT_W].root));
		if (front_d[ROOT_W].z < 0) begin
			theta_d[0].theta.den = -ze;
			theta_d[0].theta.num = -re;
			theta_d[0].theta.ang = ANG_PI;
		end else begin
			theta_d[0].theta.den = ze;
			theta_d[0].theta.num = re;
			theta_d[0].theta.ang = '0;
		end
		phi_sum = front_d[ROOT_W].phi.ang[31:0] + 32'd32768;
		if (front_d[ROOT_W].phi_zero) begin
			theta_d[0].phi16 = '0;
		end else begin
			theta_d[0].phi16 = phi_sum[31:16];
		end
		theta_d[0].all_zero = front_d[ROOT_W].all_zero;
	end

	assign theta_valid[0]      = front_valid[ROOT_W];
	assign front_ready[ROOT_W] = theta_ready[0];

	generate
		for (k = 0; k < CORDIC_ITERS; k++) begin : g_theta
			dtt_theta_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.step     (STEP_W'(k)),
				.up_valid (theta_valid[k]),
				.up_ready (theta_ready[k]),
				.up_data  (theta_d[k]),
				.dn_valid (theta_valid[k+1]),
				.dn_ready (theta_ready[k+1]),
				.dn_data  (theta_d[k+1])
			);
		end
	endgenerate

	dtt_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.dims     (dims),
		.up_valid (theta_valid[CORDIC_ITERS]),
		.up_ready (theta_ready[CORDIC_ITERS]),
		.up_data  (theta_d[CORDIC_ITERS]),
		.dn_valid (texel_valid),
		.dn_ready (texel_ready),
		.dn_data  (texel)
	);

	// an accepted request always lands in the input stage
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		dir_valid && dir_ready |=> valid_s1)
		else $error("accepted request lost at input stage");

	// a blocked input stage keeps its squares
	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !front_ready[0] |=> valid_s1 && $stable(xx_s1) && $stable(yy_s1))
		else $error("input stage changed while blocked");

	// an empty input stage never refuses a request
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> dir_ready)
		else $error("input refused while input stage empty");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import dtt_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int RAND_PHASES   = 7;
	localparam int PHASE_ITEMS   = 250;
	localparam int PIPE_LATENCY  = 51;
	localparam longint ANGLE_PI  = 64'sd2147483648;

	// atan(2^-i) in units of pi/2^31
	localparam longint ATAN_STEP [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	typedef struct {
		logic [CFG_W-1:0]       h;
		logic [CFG_W-1:0]       w;
		logic signed [IN_W-1:0] x;
		logic signed [IN_W-1:0] y;
		logic signed [IN_W-1:0] z;
		bit                     fixed_exp;
		logic [DIM_W-1:0]       row;
		logic [DIM_W-1:0]       col;
	} dir_case_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             dir_valid;
	logic             dir_ready;
	dir_req_t         dir;
	logic             texel_valid;
	logic             texel_ready;
	texel_t           texel;

	// local copy of the map size registers
	logic [CFG_W-1:0] height_reg = MAP_HEIGHT_RST;
	logic [CFG_W-1:0] width_reg  = MAP_WIDTH_RST;

	texel_t expected_texels [$];
	int     errors = 0;
	int     n_dirs = 0;
	int     n_texels = 0;
	int     n_sizes = 0;
	int     src_idle_pct = 0;
	int     sink_idle_pct = 0;

	direction_to_equirect_texel_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.dir_valid   (dir_valid),
		.dir_ready   (dir_ready),
		.dir         (dir),
		.texel_valid (texel_valid),
		.texel_ready (texel_ready),
		.texel       (texel)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// vectoring CORDIC, angle of (den, num) in units of pi/2^31
	function automatic longint cordic_angle(input longint num_in, input longint den_in);
		longint num, den, a, b, ang;
		num = num_in;
		den = den_in;
		ang = 0;
		if (den < 0) begin
			den = -den;
			num = -num;
			ang = ANGLE_PI;
		end
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			a = den;
			b = num;
			if (b >= 0) begin
				den = a + (b >>> i);
				num = b - (a >>> i);
				ang = ang + ATAN_STEP[i];
			end else begin
				den = a - (b >>> i);
				num = b + (a >>> i);
				ang = ang - ATAN_STEP[i];
			end
		end
		return ang;
	endfunction

	// bitwise integer square root, floor
	function automatic longint unsigned int_root(input longint unsigned v_in);
		longint unsigned v, res, probe;
		v = v_in;
		res = 0;
		probe = 64'd1 << 62;
		while (probe > v) probe = probe >> 2;
		while (probe != 0) begin
			if (v >= res + probe) begin
				v = v - (res + probe);
				res = (res >> 1) + probe;
			end else begin
				res = res >> 1;
			end
			probe = probe >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned clamp_dim(input logic [CFG_W-1:0] r);
		if (r == 0)
			return 1;
		if (r > MAX_DIM)
			return MAX_DIM;
		return r;
	endfunction

	// texel that a direction lands on under the current map size
	function automatic texel_t map_direction(input dir_req_t d);
		longint x, y, z, t, angle;
		longint unsigned h, w, sq, r, phi16, theta16, row, col;
		texel_t res;
		x = $signed(d.dir_x);
		y = $signed(d.dir_y);
		z = $signed(d.dir_z);
		h = clamp_dim(height_reg);
		w = clamp_dim(width_reg);
		phi16 = 0;
		theta16 = 0;
		if (x != 0 || y != 0) begin
			angle = cordic_angle(y * 65536, x * 65536);
			phi16 = ((($unsigned(angle) & 64'hFFFF_FFFF) + 32768) >> 16) & 64'hFFFF;
		end
		if (x != 0 || y != 0 || z != 0) begin
			sq = $unsigned(x * x + y * y);
			r = int_root(sq << 32);
			t = cordic_angle($signed(r), z * 65536);
			// CORDIC residue can stray past the ends of [0, pi]
			if (t < 0)
				t = 0;
			if (t > ANGLE_PI)
				t = ANGLE_PI;
			theta16 = ($unsigned(t) + 32768) >> 16;
		end
		row = (theta16 * (h - 1) + 16384) >> 15;
		if (row > h - 1)
			row = h - 1;
		col = (phi16 * (w - 1) + 32768) >> 16;
		if (col > w - 1)
			col = w - 1;
		res.texel_row = DIM_W'(row);
		res.texel_col = DIM_W'(w - 1 - col);
		return res;
	endfunction

	function automatic logic [IN_W-1:0] extreme_component();
		case ($urandom_range(4))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0001;
			default: return 16'h0000;
		endcase
	endfunction

	function automatic dir_req_t random_direction();
		dir_req_t d;
		d.dir_x = IN_W'($urandom);
		d.dir_y = IN_W'($urandom);
		d.dir_z = IN_W'($urandom);
		case ($urandom_range(9))
			0: begin
				// tiny vectors, coarse angles
				d.dir_x = IN_W'($urandom_range(8)) - 16'd4;
				d.dir_y = IN_W'($urandom_range(8)) - 16'd4;
				d.dir_z = IN_W'($urandom_range(8)) - 16'd4;
			end
			1: begin
				// on an axis or a coordinate plane
				if ($urandom_range(1)) d.dir_x = '0;
				if ($urandom_range(1)) d.dir_y = '0;
				if ($urandom_range(1)) d.dir_z = '0;
			end
			2: begin
				d.dir_x = extreme_component();
				d.dir_y = extreme_component();
				d.dir_z = extreme_component();
			end
			3: begin
				// just either side of the +x seam, where phi wraps
				d.dir_x = IN_W'($urandom_range(32767, 1000));
				d.dir_y = IN_W'($urandom_range(6)) - 16'd3;
			end
			default: ;
		endcase
		return d;
	endfunction

	// result side: random back-pressure, change at the falling edge
	always @(negedge clk)
		texel_ready <= ($urandom_range(99) >= sink_idle_pct);

	// compare each returned texel with the oldest expectation
	always @(posedge clk) begin
		texel_t want;
		if (arst_n && texel_valid && texel_ready) begin
			n_texels++;
			if (expected_texels.size() == 0) begin
				$error("texel with no request outstanding: row %0d col %0d",
					texel.texel_row, texel.texel_col);
				errors++;
			end else begin
				want = expected_texels.pop_front();
				if (texel.texel_row !== want.texel_row) begin
					$error("texel_row: expected %0d, got %0d", want.texel_row, texel.texel_row);
					errors++;
				end
				if (texel.texel_col !== want.texel_col) begin
					$error("texel_col: expected %0d, got %0d", want.texel_col, texel.texel_col);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("testbench: done, errors");
		$finish;
	end

	// present one request, with optional idle cycles first, and wait for acceptance
	task automatic send_dir(input dir_req_t d, input texel_t want);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			dir_valid <= 1'b0;
			@(negedge clk);
		end
		dir <= d;
		dir_valid <= 1'b1;
		@(posedge clk);
		while (!dir_ready) @(posedge clk);
		expected_texels.push_back(want);
		n_dirs++;
	endtask

	task automatic drain();
		@(negedge clk);
		dir_valid <= 1'b0;
		while (expected_texels.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_MAP_HEIGHT)
			height_reg = val;
		else if (idx == REG_MAP_WIDTH)
			width_reg = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_map_size(input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] w);
		drain();
		write_reg(REG_MAP_HEIGHT, h);
		write_reg(REG_MAP_WIDTH, w);
		n_sizes++;
	endtask

	initial begin
		dir_case_t dir_cases [23];
		dir_req_t d;
		texel_t want;
		logic [CFG_W-1:0] ph, pw;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		dir_valid = 1'b0;
		dir = '0;

		// h, w, x, y, z, typed-in, row, col
		dir_cases = '{
			'{1024, 2048,      0,      0,      0, 1, 0, 2047},
			'{1024, 2048,  32767,      0,      0, 0, 0, 0},
			'{1024, 2048, -32768,      0,      0, 0, 0, 0},
			'{1024, 2048,      0,  32767,      0, 0, 0, 0},
			'{1024, 2048,      0, -32768,      0, 0, 0, 0},
			'{1024, 2048,      0,      0,  32767, 0, 0, 0},
			'{1024, 2048,      0,      0, -32768, 0, 0, 0},
			'{1024, 2048, -32768, -32768, -32768, 0, 0, 0},
			'{1024, 2048,  32767,  32767,  32767, 0, 0, 0},
			'{1024, 2048,  32767,     -1,      0, 0, 0, 0},
			'{1024, 2048,     -1,      1,     -1, 0, 0, 0},
			'{1024, 2048,      1,     -1,      1, 0, 0, 0},
			'{1024, 2048, -32768,  32767,      0, 0, 0, 0},
			'{1024, 2048,      1,      1,      1, 0, 0, 0},
			'{   1,    1,  12345,     -3,     77, 1, 0, 0},
			'{   0,    0, -32768,  32767,     -1, 1, 0, 0},
			'{8191,    1,      0,      0,      0, 1, 0, 0},
			'{   2,    2,      0,      0,      0, 1, 0, 1},
			'{4096, 4096,      0,      0,      0, 1, 0, 4095},
			'{4096, 4096, -32768,     -1, -32768, 0, 0, 0},
			'{8191, 8191,    100,   -200,   -300, 0, 0, 0},
			'{8191, 8191,  32767,     -1,  32767, 0, 0, 0},
			'{4097, 5000,     -7,      3,      0, 0, 0, 0}
		};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed requests, first under the reset map size
		src_idle_pct = 15;
		sink_idle_pct = 74;
		foreach (dir_cases[i]) begin
			if (dir_cases[i].h != height_reg || dir_cases[i].w != width_reg)
				set_map_size(dir_cases[i].h, dir_cases[i].w);
			d.dir_x = dir_cases[i].x;
			d.dir_y = dir_cases[i].y;
			d.dir_z = dir_cases[i].z;
			if (dir_cases[i].fixed_exp) begin
				want.texel_row = dir_cases[i].row;
				want.texel_col = dir_cases[i].col;
			end else begin
				want = map_direction(d);
			end
			send_dir(d, want);
		end

		// random requests, one map size per phase
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: begin ph = 4096; pw = 4096; end
				1: begin ph = 2;    pw = 4096; end
				2: begin ph = 4096; pw = 2;    end
				4: begin ph = 8191; pw = 5000; end
				6: begin ph = 720;  pw = 1440; end
				default: begin
					ph = CFG_W'($urandom_range(MAX_DIM, 1));
					pw = CFG_W'($urandom_range(MAX_DIM, 1));
				end
			endcase
			set_map_size(ph, pw);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// slow sink / slow source / full rate, by thirds of the run
				if (p * PHASE_ITEMS + k < RAND_PHASES * PHASE_ITEMS / 3) begin
					src_idle_pct = 15;
					sink_idle_pct = 74;
				end else if (p * PHASE_ITEMS + k < 2 * RAND_PHASES * PHASE_ITEMS / 3) begin
					src_idle_pct = 74;
					sink_idle_pct = 15;
				end else begin
					src_idle_pct = 0;
					sink_idle_pct = 0;
				end
				d = random_direction();
				send_dir(d, map_direction(d));
			end
		end

		drain();
		repeat (PIPE_LATENCY + 10) @(negedge clk);

		$display("summary: %0d directions sent, %0d texels returned, %0d map sizes",
			n_dirs, n_texels, n_sizes);
		$display("summary: axes, seams, zero vector and register clamping covered");
		if (errors == 0 && expected_texels.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/dtt_pkg.sv
rtl/core/dtt_front_cell.sv
rtl/core/dtt_theta_cell.sv
rtl/core/dtt_scale.sv
rtl/core/direction_to_equirect_texel_core.sv
verif/testbench.sv
